/* design/lru_pkg.sv */
// Package: shared types, constants and controller commands for the LRU cache
package lru_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int KEY_W     = 32;
    localparam int HND_W     = 32;
    localparam int SZ_W      = 24;
    localparam int TOT_W     = 28;
    localparam int CNT_W     = 5;
    localparam int CFG_W     = 32;
    localparam int IDX_W     = 2;

    localparam logic [IDX_W-1:0] REG_COUNT_LIMIT = 2'd0;
    localparam logic [IDX_W-1:0] REG_SIZE_LIMIT  = 2'd1;
    localparam logic [IDX_W-1:0] REG_MIN_ENTRIES = 2'd2;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_TRIM   = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] key;
        logic             fill_found;
        logic [HND_W-1:0] fill_handle;
        logic [SZ_W-1:0]  fill_size;
    } t_in;

    typedef struct packed {
        logic             hit;
        logic             not_found;
        logic [HND_W-1:0] data_handle;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
        logic             last;
        logic [CNT_W-1:0] entry_count;
        logic [TOT_W-1:0] total_size;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item, reset search pointer
        logic search;    // examine one recency position
        logic hit_move;  // move matched position to front, emit hit
        logic miss_nf;   // emit not_found
        logic fill;      // insert fill (evicting oldest if full)
        logic trim_ev;   // evict oldest, emit
        logic trim_none; // emit nothing-to-trim result
        logic last;      // mark emitted result as last
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic match;       // current search position matches
        logic search_done; // pointer reached held count or a match was found
        logic trim_need;   // trim condition holds now
        logic trim_more;   // trim condition still holds after evicting the oldest
        logic kind;        // kind of the captured item
        logic fill_found;  // backing store holds the captured key
    } t_sts;

endpackage

/* design/lru_ctrl.sv */
// Controller: sequences lookup search, fill, and trim evictions
module lru_ctrl #(
    parameter int DEPTH = lru_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_out_busy,
    input  lru_pkg::t_sts i_sts,
    output lru_pkg::t_cmd o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_TRIM   = 4'b0100,
        S_WAIT   = 4'b1000
    } t_state;

    localparam int NW = $clog2(DEPTH + 1);

    t_state        r_state, n_state;
    logic [NW-1:0] r_n, n_n;

    always_comb begin
        n_state = r_state;
        n_n = r_n;
        o_cmd = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_n = '0;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                // captured item settles the status before searching or trimming
                n_state = (i_sts.kind == lru_pkg::KIND_TRIM) ? S_TRIM : S_SEARCH;
            end
            S_SEARCH: begin
                if (!i_out_busy) begin
                    if (i_sts.search_done) begin
                        o_cmd.last = 1'b1;
                        if (i_sts.match) o_cmd.hit_move = 1'b1;
                        else if (!i_sts.fill_found) o_cmd.miss_nf = 1'b1;
                        else o_cmd.fill = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.search = 1'b1;
                    end
                end
            end
            S_TRIM: begin
                if (!i_out_busy) begin
                    if (!i_sts.trim_need) begin
                        o_cmd.trim_none = 1'b1;
                        o_cmd.last = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.trim_ev = 1'b1;
                        // last flag is known before the eviction is registered
                        if (!i_sts.trim_more || r_n == NW'(DEPTH - 1)) begin
                            o_cmd.last = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_n = r_n + NW'(1);
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n <= '0;
        end else begin
            r_state <= n_state;
            r_n <= n_n;
        end
    end
endmodule

/* design/lru_dp.sv */
// Datapath: entry storage, recency order, totals and result register
module lru_dp #(
    parameter int DEPTH = lru_pkg::DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lru_pkg::t_in              i_in,
    input  lru_pkg::t_cmd             i_cmd,
    input  logic                      i_cfg_we,
    input  logic [lru_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [lru_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_out_stall,
    output logic                      o_out_valid,
    output lru_pkg::t_out             o_out,
    output logic                      o_out_busy,
    output lru_pkg::t_sts             o_sts
);
    localparam int SW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);
    localparam logic [lru_pkg::TOT_W-1:0] SAT = '1;

    logic [lru_pkg::KEY_W-1:0] r_keys [DEPTH];
    logic [lru_pkg::HND_W-1:0] r_hnds [DEPTH];
    logic [lru_pkg::SZ_W-1:0]  r_szs  [DEPTH];
    logic [SW-1:0]             r_ord  [DEPTH];
    logic [NW-1:0]             r_cnt;
    logic [lru_pkg::TOT_W-1:0] r_tot;
    logic [lru_pkg::CNT_W-1:0] r_cnt_lim, r_min;
    logic [lru_pkg::CFG_W-1:0] r_sz_lim;
    lru_pkg::t_in              r_item;
    logic [NW-1:0]             r_ptr;
    logic                      r_match;
    logic [SW-1:0]             r_mpos;
    logic                      r_vld;
    lru_pkg::t_out             r_out;
    lru_pkg::t_out             n_out;

    logic [SW-1:0]             ptr_s, old_pos, ins_pos, mv_pos, mv_slot;
    logic [SW-1:0]             old_slot;
    logic [lru_pkg::TOT_W-1:0] tot_sub, tot_base, tot_fill;
    logic [lru_pkg::TOT_W:0]   tot_add;
    logic [NW-1:0]             cnt_base, cnt_m1;
    logic                      full, cnt_ok, sz_ok, do_mv, emit;
    logic                      cnt_ok_m1, sz_ok_m1;
    logic [6:0]                cnt_ext, min_ext, lim_ext, cnt_m1_ext;

    assign ptr_s    = r_ptr[SW-1:0];
    assign old_pos  = SW'(r_cnt - NW'(1));
    assign old_slot = r_ord[old_pos];
    assign full     = (r_cnt == NW'(DEPTH));
    assign tot_sub  = (r_tot >= lru_pkg::TOT_W'(r_szs[old_slot]))
                    ? r_tot - lru_pkg::TOT_W'(r_szs[old_slot]) : '0;

    assign cnt_ext = 7'(r_cnt);
    assign min_ext = 7'(r_min);
    assign lim_ext = 7'(r_cnt_lim);
    assign cnt_ok  = (r_cnt_lim == '0) || (cnt_ext < lim_ext);
    assign sz_ok   = (r_sz_lim == '0) || (32'(r_tot) < r_sz_lim);

    // trim condition as it will stand once the oldest entry is gone
    assign cnt_m1     = r_cnt - NW'(1);
    assign cnt_m1_ext = 7'(cnt_m1);
    assign cnt_ok_m1  = (r_cnt_lim == '0) || (cnt_m1_ext < lim_ext);
    assign sz_ok_m1   = (r_sz_lim == '0) || (32'(tot_sub) < r_sz_lim);

    assign o_sts.trim_need   = (cnt_ext > min_ext) && (r_cnt != '0) && !(cnt_ok && sz_ok);
    assign o_sts.trim_more   = (cnt_m1_ext > min_ext) && (cnt_m1 != '0)
                             && !(cnt_ok_m1 && sz_ok_m1);
    assign o_sts.match       = r_match;
    assign o_sts.search_done = (r_ptr == r_cnt) || r_match;
    assign o_sts.kind        = r_item.kind;
    assign o_sts.fill_found  = r_item.fill_found;

    assign o_out_busy  = r_vld && i_out_stall;
    assign o_out_valid = r_vld;
    assign o_out       = r_out;

    // fill base: after optional eviction of the oldest
    assign cnt_base = full ? r_cnt - NW'(1) : r_cnt;
    assign tot_base = full ? tot_sub : r_tot;
    assign tot_add  = {1'b0, tot_base} + (lru_pkg::TOT_W+1)'(r_item.fill_size);
    assign tot_fill = tot_add[lru_pkg::TOT_W] ? SAT : tot_add[lru_pkg::TOT_W-1:0];
    assign ins_pos  = SW'(cnt_base);
    assign do_mv    = i_cmd.hit_move || i_cmd.fill;
    assign mv_pos   = i_cmd.hit_move ? r_mpos : ins_pos;
    assign mv_slot  = r_ord[mv_pos];
    assign emit     = i_cmd.hit_move || i_cmd.fill || i_cmd.miss_nf || i_cmd.trim_ev
                    || i_cmd.trim_none;

    always_comb begin
        n_out = '0;
        n_out.last = i_cmd.last;
        n_out.entry_count = lru_pkg::CNT_W'(r_cnt);
        n_out.total_size = r_tot;
        if (i_cmd.hit_move) begin
            n_out.hit = 1'b1;
            n_out.data_handle = r_hnds[r_ord[r_mpos]];
        end
        if (i_cmd.miss_nf) n_out.not_found = 1'b1;
        if (i_cmd.fill) begin
            n_out.data_handle = r_item.fill_handle;
            n_out.evicted = full;
            n_out.evicted_key = full ? r_keys[old_slot] : '0;
            n_out.entry_count = lru_pkg::CNT_W'(cnt_base + NW'(1));
            n_out.total_size = tot_fill;
        end
        if (i_cmd.trim_ev) begin
            n_out.evicted = 1'b1;
            n_out.evicted_key = r_keys[old_slot];
            n_out.entry_count = lru_pkg::CNT_W'(cnt_m1);
            n_out.total_size = tot_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_tot <= '0; r_vld <= 1'b0;
            r_cnt_lim <= '0; r_sz_lim <= '0; r_min <= '0;
            for (int i = 0; i < DEPTH; i++) r_ord[i] <= SW'(i);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lru_pkg::REG_COUNT_LIMIT: r_cnt_lim <= i_cfg_data[lru_pkg::CNT_W-1:0];
                    lru_pkg::REG_SIZE_LIMIT:  r_sz_lim  <= i_cfg_data;
                    lru_pkg::REG_MIN_ENTRIES: r_min     <= i_cfg_data[lru_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end
            if (emit) begin
                r_vld <= 1'b1;
                r_out <= n_out;
            end else if (r_vld && !i_out_stall) begin
                r_vld <= 1'b0;
            end
            if (i_cmd.load) begin
                r_item <= i_in; r_ptr <= '0; r_match <= 1'b0;
            end
            if (i_cmd.search) begin
                if (r_keys[r_ord[ptr_s]] == r_item.key) begin
                    r_match <= 1'b1; r_mpos <= ptr_s;
                end else begin
                    r_ptr <= r_ptr + NW'(1);
                end
            end
            if (do_mv) begin
                for (int i = 1; i < DEPTH; i++)
                    if (SW'(i) <= mv_pos) r_ord[i] <= r_ord[i-1];
                r_ord[0] <= mv_slot;
            end
            if (i_cmd.fill) begin
                r_keys[mv_slot] <= r_item.key;
                r_hnds[mv_slot] <= r_item.fill_handle;
                r_szs[mv_slot]  <= r_item.fill_size;
                r_cnt <= cnt_base + NW'(1);
                r_tot <= tot_fill;
            end else if (i_cmd.trim_ev) begin
                r_cnt <= cnt_m1;
                r_tot <= tot_sub;
            end
        end
    end
endmodule

/* design/lru_cache_size_limited_core.sv */
// Top level: size-limited LRU cache core
//
// Input channel (i_in_valid / o_in_stall, payload i_in): one transfer is one
// lookup or one trim item. Output channel (o_out_valid / i_out_stall, payload
// o_out): one transfer per result. A lookup gives one result; a trim gives
// one result per evicted entry (or one empty result), the final one with last.
// A lookup passes a wait state, then a sequential tag search over the
// recency order. A trim gives its first result after the wait state,
// then one per cycle while the receiver does not stall.
// One item is worked on at a time; the next is taken in the cycle after the
// current item's last result is registered.
// A stalled receiver holds the result register and freezes the sequencer;
// the last flag of each trim result is settled before it is registered.
// Configuration: i_cfg_we writes register i_cfg_idx with i_cfg_data at the
// edge. The user must write only while idle; the block does not enforce it.
// Reset (synchronous, i_rst_n low): empty cache, identity recency order,
// zero totals and limits. Entry storage is not cleared.
module lru_cache_size_limited_core #(
    parameter int DEPTH = lru_pkg::DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  lru_pkg::t_in              i_in,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output lru_pkg::t_out             o_out,
    input  logic                      i_cfg_we,
    input  logic [lru_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [lru_pkg::CFG_W-1:0] i_cfg_data
);
    lru_pkg::t_cmd cmd;
    lru_pkg::t_sts sts;
    logic          busy;

    lru_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall,
        .i_out_busy(busy), .i_sts(sts), .o_cmd(cmd)
    );

    lru_dp #(.DEPTH(DEPTH)) u_dp (
        .i_clk, .i_rst_n, .i_in, .i_cmd(cmd),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_out_stall, .o_out_valid, .o_out, .o_out_busy(busy), .o_sts(sts)
    );
endmodule
